// ----- sv/mtbr_pkg.sv -----
// -----------------------------------------------------------------------------
// mtbr_pkg
// Shared constants and types of the banded rectangle extractor.
// -----------------------------------------------------------------------------
`default_nettype none
package mtbr_pkg;
    localparam int MAX_RUNS  = 32;
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = 12;
    localparam int WID_W     = 13;
    localparam int IDX_W     = $clog2(MAX_RUNS);
    localparam int CNT_W     = $clog2(MAX_RUNS + 1);
    localparam logic [WID_W-1:0] HEIGHT_MAX = WID_W'(4096);
    localparam logic [CNT_W-1:0] RUNS_LIM   = CNT_W'(MAX_RUNS);
    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(MAX_WIDTH - 1);

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [WID_W-1:0] w;
    } t_run;

    typedef struct packed {
        logic             emit;
        logic             emit_last;
        logic             commit_new;
        logic             commit_grow;
        logic             clear;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] line_count;
        logic [CNT_W-1:0] band_count;
        logic             band_open;
        logic             entry_diff;
        logic             out_free;
        logic             eol;
        logic             eoi;
    } t_sts;
endpackage
`default_nettype wire

// ----- sv/mtbr_ctrl.sv -----
// -----------------------------------------------------------------------------
// mtbr_ctrl
// Sequencer for line compare, band emission and image-end flush.
// -----------------------------------------------------------------------------
`default_nettype none
module mtbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_acc,
    input  wire mtbr_pkg::t_sts i_sts,
    output mtbr_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);
    import mtbr_pkg::*;

    typedef enum logic [1:0] {ST_PIX, ST_CMP, ST_OLD, ST_FIN} t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_eoi, n_eoi;
    logic             w_last_k;

    assign o_in_ready = (r_state == ST_PIX);
    assign w_last_k   = (r_k == i_sts.band_count - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_eoi   = r_eoi;
        o_cmd   = '0;
        o_cmd.idx = r_k[IDX_W-1:0];
        case (r_state)
            ST_PIX: begin
                if (i_in_acc && i_sts.eol) begin
                    n_eoi   = i_sts.eoi;
                    n_k     = '0;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.band_open && i_sts.band_count == i_sts.line_count &&
                    r_k == i_sts.line_count) begin
                    o_cmd.commit_grow = 1'b1;
                    n_k     = '0;
                    n_state = r_eoi ? ST_FIN : ST_PIX;
                end else if (i_sts.band_open && i_sts.band_count == i_sts.line_count &&
                             !i_sts.entry_diff) begin
                    n_k = r_k + CNT_W'(1);
                end else if (i_sts.band_open && i_sts.band_count != '0) begin
                    n_k     = '0;
                    n_state = ST_OLD;
                end else begin
                    o_cmd.commit_new = 1'b1;
                    n_k     = '0;
                    n_state = r_eoi ? ST_FIN : ST_PIX;
                end
            end
            ST_OLD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = w_last_k && !(r_eoi && i_sts.line_count != '0);
                    if (w_last_k) begin
                        o_cmd.commit_new = 1'b1;
                        n_k     = '0;
                        n_state = r_eoi ? ST_FIN : ST_PIX;
                    end else begin
                        n_k = r_k + CNT_W'(1);
                    end
                end
            end
            ST_FIN: begin
                if (i_sts.band_count == '0) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_PIX;
                end else if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = w_last_k;
                    if (w_last_k) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_PIX;
                    end else begin
                        n_k = r_k + CNT_W'(1);
                    end
                end
            end
            default: n_state = ST_PIX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PIX;
            r_k     <= '0;
            r_eoi   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_eoi   <= n_eoi;
        end
    end
endmodule
`default_nettype wire

// ----- sv/mtbr_dp.sv -----
// -----------------------------------------------------------------------------
// mtbr_dp
// Run detection, line and band run buffers, band state and output register.
// -----------------------------------------------------------------------------
`default_nettype none
module mtbr_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_thresh,
    input  wire logic          i_in_acc,
    input  wire logic [31:0]   i_pixel,
    input  wire logic          i_eol,
    input  wire logic          i_eoi,
    input  wire mtbr_pkg::t_cmd i_cmd,
    output mtbr_pkg::t_sts      o_sts,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [55:0]        o_out_data,
    output logic               o_out_last,
    output logic               o_out_drop
);
    import mtbr_pkg::*;

    t_run             r_buf_a [MAX_RUNS];
    t_run             r_buf_b [MAX_RUNS];
    logic             r_sel;
    logic [COL_W-1:0] r_column, r_row, r_run_start, r_band_top;
    logic             r_in_run, r_band_open, r_dropped;
    logic [CNT_W-1:0] r_line_count, r_band_count;
    logic [WID_W-1:0] r_height;
    logic             r_o_valid, r_o_last, r_o_drop;
    logic [55:0]      r_o_data;

    logic             w_opaque, w_eol, w_add;
    t_run             w_new, w_line_rd, w_band_rd;

    assign w_opaque  = (i_pixel >= i_thresh);
    assign w_eol     = i_eol || i_eoi || (r_column == COL_LAST);
    assign w_line_rd = r_sel ? r_buf_b[i_cmd.idx] : r_buf_a[i_cmd.idx];
    assign w_band_rd = r_sel ? r_buf_a[i_cmd.idx] : r_buf_b[i_cmd.idx];

    always_comb begin
        w_add   = 1'b0;
        w_new.x = r_run_start;
        w_new.w = {1'b0, r_column} - {1'b0, r_run_start};
        if (w_opaque && !r_in_run) begin
            w_add   = w_eol;
            w_new.x = r_column;
            w_new.w = WID_W'(1);
        end else if (!w_opaque && r_in_run) begin
            w_add = 1'b1;
        end else if (w_opaque && r_in_run) begin
            w_add   = w_eol;
            w_new.w = {1'b0, r_column} - {1'b0, r_run_start} + WID_W'(1);
        end
    end

    assign o_sts.line_count = r_line_count;
    assign o_sts.band_count = r_band_count;
    assign o_sts.band_open  = r_band_open;
    assign o_sts.entry_diff = (w_line_rd != w_band_rd);
    assign o_sts.out_free   = !r_o_valid || i_out_ready;
    assign o_sts.eol        = w_eol;
    assign o_sts.eoi        = i_eoi;

    always_ff @(posedge i_clk) begin
        if (i_in_acc && w_add && r_line_count < RUNS_LIM) begin
            if (r_sel) begin
                r_buf_b[r_line_count[IDX_W-1:0]] <= w_new;
            end else begin
                r_buf_a[r_line_count[IDX_W-1:0]] <= w_new;
            end
        end
        if (i_cmd.emit) begin
            r_o_data <= {6'd0, r_height, w_band_rd.w, r_band_top, w_band_rd.x};
            r_o_last <= i_cmd.emit_last;
            r_o_drop <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel        <= 1'b0;
            r_column     <= '0;
            r_row        <= '0;
            r_run_start  <= '0;
            r_in_run     <= 1'b0;
            r_line_count <= '0;
            r_band_count <= '0;
            r_band_top   <= '0;
            r_height     <= '0;
            r_band_open  <= 1'b0;
            r_dropped    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_in_acc) begin
                if (w_opaque && !r_in_run) begin
                    r_run_start <= r_column;
                end
                r_in_run <= w_opaque && !w_eol;
                r_column <= w_eol ? '0 : r_column + COL_W'(1);
                if (w_add) begin
                    if (r_line_count < RUNS_LIM) begin
                        r_line_count <= r_line_count + CNT_W'(1);
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end
            end
            if (i_cmd.commit_grow) begin
                if (r_height < HEIGHT_MAX) begin
                    r_height <= r_height + WID_W'(1);
                end
                r_row        <= r_row + COL_W'(1);
                r_line_count <= '0;
            end
            if (i_cmd.commit_new) begin
                r_sel        <= ~r_sel;
                r_band_count <= r_line_count;
                r_band_top   <= r_row;
                r_height     <= WID_W'(1);
                r_band_open  <= 1'b1;
                r_row        <= r_row + COL_W'(1);
                r_line_count <= '0;
            end
            if (i_cmd.clear) begin
                r_column     <= '0;
                r_row        <= '0;
                r_run_start  <= '0;
                r_in_run     <= 1'b0;
                r_line_count <= '0;
                r_band_count <= '0;
                r_band_top   <= '0;
                r_height     <= '0;
                r_band_open  <= 1'b0;
                r_dropped    <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_out_last  = r_o_last;
    assign o_out_drop  = r_o_drop;
endmodule
`default_nettype wire

// ----- sv/mask_to_banded_rectangles.sv -----
// -----------------------------------------------------------------------------
// mask_to_banded_rectangles
// Thresholds a pixel stream and merges identical lines of runs into bands.
// -----------------------------------------------------------------------------
// Channel   Direction  Words
// s_axis    in         one pixel per word
// m_axis    out        one rectangle per word
// APB       in         threshold register at address 0
//
// s_axis stays ready after a pixel that does not end a line.
// At a line end the line's runs are compared one per cycle,
// then a changed band is emitted one rectangle per cycle while m_axis is ready.
// Reset is synchronous; no clearing pass is needed.
// The output register lets the last rectangle wait while new pixels enter.
// -----------------------------------------------------------------------------
`default_nettype none
module mask_to_banded_rectangles (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // pixel
    input  wire logic        s_axis_tlast,
    input  wire logic        s_axis_tuser,   // end_of_image
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // rect_x, rect_y, rect_width, rect_height
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // runs_dropped
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mtbr_pkg::*;

    logic [31:0] r_thresh;
    logic        w_in_acc;
    t_cmd        w_cmd;
    t_sts        w_sts;

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : r_thresh;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 32'h8000_0000;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_thresh <= pwdata;
        end
    end

    mtbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_acc   (w_in_acc),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    mtbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_thresh    (r_thresh),
        .i_in_acc    (w_in_acc),
        .i_pixel     (s_axis_tdata),
        .i_eol       (s_axis_tlast),
        .i_eoi       (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_drop  (m_axis_tuser)
    );
endmodule
`default_nettype wire

// ----- sv/mtbr_chk.sv -----
// -----------------------------------------------------------------------------
// mtbr_chk
// Port-level checks of the banded rectangle extractor.
// -----------------------------------------------------------------------------
`default_nettype none
module mtbr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:24] != 13'd0)
        else $error("zero rectangle width");

    a_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[49:37] != 13'd0)
        else $error("zero rectangle height");

    a_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("pixel taken during line compare");
endmodule

bind mask_to_banded_rectangles mtbr_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
